// ===== rtl/grpt_pkg.sv =====
// Package: types, constants and classification helpers for the pattern tokenizer.
`timescale 1ns / 1ps
package grpt_pkg;

  localparam int unsigned MaxTokens     = 512;
  localparam int unsigned MaxPatternLen = 1024;
  localparam int unsigned MaxDepth      = 15;
  localparam int unsigned CntW          = $clog2(MaxTokens + 1);
  localparam int unsigned PosW          = $clog2(MaxPatternLen + 1);
  localparam int unsigned QDepth        = 4;
  localparam int unsigned QIdxW         = $clog2(QDepth);

  typedef enum logic [3:0] {
    KEmpty = 4'd0, KLit = 4'd1, KCount = 4'd2, KSet = 4'd3, KStar = 4'd4,
    KOpt = 4'd5, KPlus = 4'd6, KAny = 4'd7, KAnys = 4'd8, KOpen = 4'd9,
    KBranch = 4'd10, KClose = 4'd11, KClass = 4'd12, KOpts = 4'd13
  } kind_e;

  typedef enum logic [4:0] {
    StToken = 5'd0, StDone = 5'd1, StOverflow = 5'd2, StEndEsc = 5'd3,
    StBadEsc = 5'd4, StEndUs = 5'd5, StBadUs = 5'd6, StEndCnt = 5'd7,
    StBadCnt = 5'd8, StBadRegex = 5'd9, StOpenSet = 5'd10, StSetBrk = 5'd11,
    StSetChar = 5'd12, StBadClose = 5'd13, StOpenGrp = 5'd14, StTooLong = 5'd16
  } status_e;

  typedef enum logic [3:0] {
    MNormal, MEsc1, MEsc2, MEsc3, MEscUs, MCntA, MCntB, MCntD, MCntE,
    MSetFirst, MSetBody
  } mode_e;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       pattern_end;
  } req_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [9:0]  token_offset;
    logic [10:0] token_length;
    logic [3:0]  nest_depth;
    logic [4:0]  status;
    logic        last_of_run;
  } rsp_t;

  // Classified work for the back end: up to two results per request.
  typedef struct packed {
    logic two;
    rsp_t r0;
    rsp_t r1;
  } job_t;

  function automatic logic is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_alnum(input logic [7:0] b);
    return is_digit(b) || (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic logic is_class(input logic [7:0] b);
    case (b)
      "i", "I", "k", "K", "f", "F", "p", "P", "s", "S", "d", "D", "x", "X",
      "o", "O", "w", "W", "h", "H", "a", "A", "l", "L", "u", "U": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_opt(input logic [7:0] b);
    case (b)
      "c", "C", "Z", "m", "M", "v", "V": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic is_lit_esc(input logic [7:0] b);
    return b == "," || b == "?" || b == "{" || b == "}";
  endfunction

  function automatic logic is_set_extra(input logic [7:0] b);
    return b == "-" || b == "_" || b == "." || b == ":";
  endfunction

endpackage

// ===== rtl/grpt_front.sv =====
// Front end: scans pattern bytes and builds result jobs.
`timescale 1ns / 1ps
module grpt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  grpt_pkg::req_t  req_i,
  output logic            req_ready_o,
  output logic            job_valid_o,
  output grpt_pkg::job_t  job_o,
  input  logic            job_ready_i
);
  import grpt_pkg::*;

  mode_e             mode_q, mode_d;
  logic              run_q, run_d, tok_q, tok_d, nest_q, nest_d;
  logic              err_q, err_d, cf_q, cf_d;
  logic [9:0]        rstart_q, rstart_d, cstart_q, cstart_d;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [3:0]        depth_q, depth_d;
  kind_e             prev_q, prev_d;
  logic [CntW-1:0]   cnt_q, cnt_d;

  logic       fire, emit, fail;
  kind_e      ekind;
  logic [9:0] eoff;
  logic [10:0] elen;
  status_e    fcode;
  logic       jvalid;
  job_t       job;
  logic [7:0] b;
  logic [9:0] p;

  assign req_ready_o = job_ready_i;
  assign fire = req_valid_i && req_ready_o;
  assign b = req_i.pattern_byte;
  assign p = pos_q[9:0];

  // Byte classification: which construct (if any) ends here.
  always_comb begin
    mode_d = mode_q;
    nest_d = nest_q;
    run_d = run_q;
    rstart_d = rstart_q;
    cstart_d = cstart_q;
    emit = 1'b0;
    fail = 1'b0;
    ekind = KEmpty;
    eoff = cstart_q;
    elen = 11'd2;
    fcode = StOverflow;
    case (mode_q)
      MNormal: begin
        cstart_d = p;
        eoff = p;
        elen = 11'd1;
        if (b == "{") begin emit = 1'b1; ekind = KOpen; end
        else if (b == "}") begin emit = 1'b1; ekind = KClose; end
        else if (b == ",") begin emit = 1'b1; ekind = KBranch; end
        else if (b == "*") begin emit = 1'b1; ekind = KAnys; end
        else if (b == "?") begin emit = 1'b1; ekind = KAny; end
        else if (b == "\\") mode_d = MEsc1;
        else if (b == "[") mode_d = MSetFirst;
        else if (!run_q) begin run_d = 1'b1; rstart_d = p; end
      end
      MEsc1: begin
        if (b == "(") begin emit = 1'b1; ekind = KOpen; end
        else if (b == ")") begin emit = 1'b1; ekind = KClose; end
        else if (b == "|") begin emit = 1'b1; ekind = KBranch; end
        else if (is_lit_esc(b)) begin
          mode_d = MNormal;
          if (!run_q) begin run_d = 1'b1; rstart_d = cstart_q; end
        end
        else if (b == "*") begin emit = 1'b1; ekind = KStar; end
        else if (b == "+") begin emit = 1'b1; ekind = KPlus; end
        else if (b == "=") begin emit = 1'b1; ekind = KOpt; end
        else if (is_class(b)) begin emit = 1'b1; ekind = KClass; end
        else if (b == "_") mode_d = MEscUs;
        else if (b == "\\") mode_d = MEsc2;
        else if (is_opt(b)) begin emit = 1'b1; ekind = KOpts; end
        else begin fail = 1'b1; fcode = StBadRegex; end
      end
      MEsc2: begin
        if (b == "\\") mode_d = MEsc3;
        else begin fail = 1'b1; fcode = StBadEsc; end
      end
      MEsc3: begin
        if (b == "{") mode_d = MCntA;
        else begin fail = 1'b1; fcode = StBadEsc; end
      end
      MEscUs: begin
        elen = 11'd3;
        if (is_class(b)) begin emit = 1'b1; ekind = KClass; end
        else begin fail = 1'b1; fcode = StBadUs; end
      end
      MCntA, MCntB: begin
        if (is_digit(b) || (mode_q == MCntA && b == "-")) mode_d = MCntB;
        else if (b == ",") mode_d = MCntD;
        else if (b == "\\") mode_d = MCntE;
        else begin fail = 1'b1; fcode = StBadCnt; end
      end
      MCntD: begin
        if (b == "\\") mode_d = MCntE;
        else if (!is_digit(b)) begin fail = 1'b1; fcode = StBadCnt; end
      end
      MCntE: begin
        elen = {1'b0, p - cstart_q} + 11'd1;
        if (b == "}") begin emit = 1'b1; ekind = KCount; end
        else begin fail = 1'b1; fcode = StBadCnt; end
      end
      MSetFirst, MSetBody: begin
        elen = {1'b0, p - cstart_q} + 11'd1;
        mode_d = MSetBody;
        if (mode_q == MSetFirst) nest_d = 1'b0;
        if (mode_q == MSetFirst && b == "^") nest_d = 1'b0;
        else if (b == "[") begin
          if (nest_q && mode_q == MSetBody) begin fail = 1'b1; fcode = StSetBrk; end
          else nest_d = 1'b1;
        end
        else if (b == "]") begin
          if (nest_q && mode_q == MSetBody) nest_d = 1'b0;
          else begin emit = 1'b1; ekind = KSet; end
        end
        else if (!(is_alnum(b) || is_set_extra(b))) begin
          fail = 1'b1; fcode = StSetChar;
        end
      end
      default: mode_d = MNormal;
    endcase
  end

  // Token emission, error and terminator handling.
  always_comb begin
    logic             empty;
    logic [CntW:0]    need;
    logic [3:0]       tdepth;
    rsp_t             tk, lt, em, st;
    tok_d = tok_q; prev_d = prev_q; cnt_d = cnt_q; depth_d = depth_q;
    cf_d = cf_q; err_d = err_q; pos_d = pos_q;
    jvalid = 1'b0;
    job = '0;
    empty = !run_q && tok_q && (ekind == KBranch || ekind == KClose) &&
            (prev_q == KOpen || prev_q == KBranch);
    need = {1'b0, cnt_q} + (CntW+1)'(run_q) + (CntW+1)'(empty) + (CntW+1)'(1);
    tdepth = depth_q;
    st = '0;
    st.last_of_run = 1'b1;
    lt = '0;
    lt.token_kind = KLit;
    lt.token_offset = rstart_q;
    lt.token_length = {1'b0, eoff - rstart_q};
    lt.nest_depth = depth_q;
    em = '0;
    em.token_kind = KEmpty;
    em.token_offset = eoff;
    em.nest_depth = depth_q;
    tk = '0;
    if (req_i.pattern_end) begin
      if (!err_q) begin
        jvalid = 1'b1;
        if (mode_q != MNormal) begin
          case (mode_q)
            MEsc1, MEsc2, MEsc3: st.status = StEndEsc;
            MEscUs: st.status = StEndUs;
            MCntA: st.status = StEndCnt;
            MSetFirst, MSetBody: st.status = StOpenSet;
            default: st.status = StBadCnt;
          endcase
          job.r0 = st;
        end else if (run_q && ({1'b0, cnt_q} + (CntW+1)'(1)) > (CntW+1)'(MaxTokens)) begin
          st.status = StOverflow;
          job.r0 = st;
        end else begin
          st.status = cf_q ? StBadClose : (depth_q != 4'd0 ? StOpenGrp : StDone);
          if (run_q) begin
            job.two = 1'b1;
            lt.token_length = 11'({1'b0, pos_q} - {1'b0, 11'(rstart_q)});
            job.r0 = lt;
            job.r1 = st;
          end else job.r0 = st;
        end
      end
    end else if (!err_q) begin
      if (pos_q >= PosW'(MaxPatternLen)) begin
        jvalid = 1'b1; err_d = 1'b1; st.status = StTooLong; job.r0 = st;
      end else begin
        pos_d = pos_q + PosW'(1);
        if (fail) begin
          jvalid = 1'b1; err_d = 1'b1; st.status = fcode; job.r0 = st;
        end else if (emit) begin
          jvalid = 1'b1;
          if (need > (CntW+1)'(MaxTokens) ||
              (ekind == KOpen && depth_q >= 4'(MaxDepth))) begin
            err_d = 1'b1; st.status = StOverflow; job.r0 = st;
          end else begin
            if (ekind == KOpen) begin
              depth_d = depth_q + 4'd1; tdepth = depth_d;
            end else if (ekind == KClose) begin
              if (depth_q == 4'd0) cf_d = 1'b1;
              else depth_d = depth_q - 4'd1;
            end
            tk.token_kind = ekind;
            tk.token_offset = eoff;
            tk.token_length = elen;
            tk.nest_depth = tdepth;
            tk.last_of_run = 1'b1;
            if (run_q) begin job.two = 1'b1; job.r0 = lt; job.r1 = tk; end
            else if (empty) begin job.two = 1'b1; job.r0 = em; job.r1 = tk; end
            else job.r0 = tk;
            cnt_d = need[CntW-1:0];
            prev_d = ekind;
            tok_d = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MNormal; run_q <= 1'b0; tok_q <= 1'b0; nest_q <= 1'b0;
      err_q <= 1'b0; cf_q <= 1'b0; rstart_q <= '0; cstart_q <= '0;
      pos_q <= '0; depth_q <= '0; prev_q <= KEmpty; cnt_q <= '0;
    end else if (fire) begin
      if (req_i.pattern_end) begin
        mode_q <= MNormal; run_q <= 1'b0; tok_q <= 1'b0; nest_q <= 1'b0;
        err_q <= 1'b0; cf_q <= 1'b0; rstart_q <= '0; cstart_q <= '0;
        pos_q <= '0; depth_q <= '0; prev_q <= KEmpty; cnt_q <= '0;
      end else if (!err_q) begin
        pos_q <= pos_d;
        err_q <= err_d;
        if (pos_q < PosW'(MaxPatternLen)) begin
          mode_q <= (emit || fail) ? MNormal : mode_d;
          nest_q <= fail ? 1'b1 : nest_d;
          cstart_q <= cstart_d;
          rstart_q <= rstart_d;
          run_q <= (emit && !err_d) ? 1'b0 : run_d;
          tok_q <= tok_d; prev_q <= prev_d; cnt_q <= cnt_d;
          depth_q <= depth_d; cf_q <= cf_d;
        end
      end
    end
  end

  assign job_valid_o = fire && jvalid;
  assign job_o = job;

  a_one_result_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_o && job_o.r0.status != StToken && !job_o.two |-> job_o.r0.last_of_run)
    else $error("status result without last flag");
  a_err_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q && fire && !req_i.pattern_end |-> !job_valid_o)
    else $error("output while error held");
  a_depth_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 4'(MaxDepth))
    else $error("group depth beyond limit");
endmodule

// ===== rtl/grpt_back.sv =====
// Back end: job queue and serializer to the result channel.
`timescale 1ns / 1ps
module grpt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            job_valid_i,
  input  grpt_pkg::job_t  job_i,
  output logic            job_ready_o,
  output logic            rsp_valid_o,
  output grpt_pkg::rsp_t  rsp_o,
  input  logic            rsp_ready_i
);
  import grpt_pkg::*;

  job_t            mem_q [QDepth];
  logic [QIdxW-1:0] wr_q, rd_q;
  logic [QIdxW:0]   cnt_q;
  logic            half_q;
  logic            push, pop, take;

  assign job_ready_o = cnt_q < (QIdxW+1)'(QDepth);
  assign rsp_valid_o = cnt_q != '0;
  assign rsp_o = (mem_q[rd_q].two && !half_q) ? mem_q[rd_q].r0 :
                 (mem_q[rd_q].two ? mem_q[rd_q].r1 : mem_q[rd_q].r0);
  assign take = rsp_valid_o && rsp_ready_i;
  assign pop = take && (!mem_q[rd_q].two || half_q);
  assign push = job_valid_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0; half_q <= 1'b0;
    end else begin
      if (push) wr_q <= wr_q + QIdxW'(1);
      if (pop) rd_q <= rd_q + QIdxW'(1);
      cnt_q <= cnt_q + (QIdxW+1)'(push) - (QIdxW+1)'(pop);
      if (pop) half_q <= 1'b0;
      else if (take) half_q <= 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QIdxW+1)'(QDepth))
    else $error("job queue overflow");
  a_half_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    half_q |-> rsp_valid_o && mem_q[rd_q].two)
    else $error("second half without pair");
  a_pop_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> rsp_o.last_of_run)
    else $error("job retired before its last result");
endmodule

// ===== rtl/glob_regex_pattern_tokenizer.sv =====
// Top level of the glob/regex pattern tokenizer.
`timescale 1ns / 1ps
// A request's results are registered in the job queue when it is accepted.
// Throughput: one request per cycle while the job queue has room; requests
//   with two results send them in turn, so the result port bounds the rate.
// A four-entry job queue decouples the scanner from the result serializer.
// Reset (rst_ni low, async) returns scan state and queue to empty.
module glob_regex_pattern_tokenizer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  grpt_pkg::req_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output grpt_pkg::rsp_t  out_data_o
);
  import grpt_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  // Scanner: classifies each byte, tracks nesting and literal runs.
  grpt_front u_front (
    .clk_i, .rst_ni,
    .req_valid_i(in_valid_i), .req_i(in_data_i), .req_ready_o(in_ready_o),
    .job_valid_o(job_valid), .job_o(job), .job_ready_i(job_ready)
  );

  // Serializer: queues jobs, delivers one result per cycle on out_ready_i.
  grpt_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_i(job), .job_ready_o(job_ready),
    .rsp_valid_o(out_valid_o), .rsp_o(out_data_o), .rsp_ready_i(out_ready_i)
  );
endmodule
